[design/deque_with_search_remove_unit_assert.svh]
// Assertion macros shared by the deque controller and datapath.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef DEQUE_WITH_SEARCH_REMOVE_UNIT_ASSERT_SVH
`define DEQUE_WITH_SEARCH_REMOVE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DQSR_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DQSR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/dqsr_pkg.sv]
// Shared types and constants for the deque with search and remove.
// No dependencies; used by the controller, datapath and top level.
`timescale 1ns / 1ps

package dqsr_pkg;

    localparam int KIND_W      = 4;
    localparam int VALUE_W     = 32;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 6;
    localparam int MAX_RESULTS = 32;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_FRONT = 4'd0,
        KIND_PUSH_BACK  = 4'd1,
        KIND_POP_FRONT  = 4'd2,
        KIND_POP_BACK   = 4'd3,
        KIND_PEEK_FRONT = 4'd4,
        KIND_PEEK_BACK  = 4'd5,
        KIND_FIND       = 4'd6,
        KIND_REMOVE     = 4'd7,
        KIND_LIST       = 4'd8
    } kind_e;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } status_e;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_END_READ,
        ST_SCAN
    } state_e;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
    } op_t;

    typedef struct packed {
        logic [VALUE_W-1:0]  value_res;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
        logic                last;
    } result_t;

    typedef struct packed {
        logic    load;
        logic    push_front;
        logic    push_back;
        logic    pop_front;
        logic    pop_back;
        logic    rd_front;
        logic    rd_back;
        logic    scan;
        logic    compact;
        logic    commit;
        logic    emit;
        logic    val_rd;
        logic    last;
        status_e status;
    } cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              empty;
        logic              full;
        logic              chk_vld;
        logic              chk_last;
        logic              chk_match;
        logic              none_removed;
    } stat_t;

endpackage

[design/dqsr_ctrl.sv]
// Controller state machine for the deque with search and remove.
// Depends on dqsr_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "deque_with_search_remove_unit_assert.svh"

module dqsr_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  dqsr_pkg::stat_t  stat,
    output dqsr_pkg::cmd_t   cmd,
    output logic             busy
);

    dqsr_pkg::state_e state_reg;
    dqsr_pkg::state_e state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dqsr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dqsr_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = dqsr_pkg::ST_DECODE;
                end
            end
            dqsr_pkg::ST_DECODE:
            begin
                if (stat.kind inside {dqsr_pkg::KIND_POP_FRONT, dqsr_pkg::KIND_POP_BACK,
                                      dqsr_pkg::KIND_PEEK_FRONT, dqsr_pkg::KIND_PEEK_BACK})
                begin
                    state_next = stat.empty ? dqsr_pkg::ST_IDLE : dqsr_pkg::ST_END_READ;
                end
                else if (stat.kind inside {dqsr_pkg::KIND_FIND, dqsr_pkg::KIND_REMOVE,
                                           dqsr_pkg::KIND_LIST})
                begin
                    state_next = stat.empty ? dqsr_pkg::ST_IDLE : dqsr_pkg::ST_SCAN;
                end
                else
                begin
                    state_next = dqsr_pkg::ST_IDLE;
                end
            end
            dqsr_pkg::ST_END_READ:
            begin
                state_next = dqsr_pkg::ST_IDLE;
            end
            dqsr_pkg::ST_SCAN:
            begin
                if (stat.chk_vld)
                begin
                    if (stat.kind == dqsr_pkg::KIND_FIND)
                    begin
                        if (stat.chk_match || stat.chk_last)
                        begin
                            state_next = dqsr_pkg::ST_IDLE;
                        end
                    end
                    else if (stat.chk_last)
                    begin
                        state_next = dqsr_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = dqsr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        cmd.status = dqsr_pkg::STAT_OK;
        cmd.last   = 1'b1;
        case (state_reg)
            dqsr_pkg::ST_IDLE:
            begin
                cmd.load = start;
            end
            dqsr_pkg::ST_DECODE:
            begin
                cmd.emit = 1'b1;
                case (stat.kind)
                    dqsr_pkg::KIND_PUSH_FRONT,
                    dqsr_pkg::KIND_PUSH_BACK:
                    begin
                        if (stat.full)
                        begin
                            cmd.status = dqsr_pkg::STAT_FULL;
                        end
                        else
                        begin
                            cmd.push_front = (stat.kind == dqsr_pkg::KIND_PUSH_FRONT);
                            cmd.push_back  = (stat.kind == dqsr_pkg::KIND_PUSH_BACK);
                        end
                    end
                    dqsr_pkg::KIND_POP_FRONT,
                    dqsr_pkg::KIND_POP_BACK,
                    dqsr_pkg::KIND_PEEK_FRONT,
                    dqsr_pkg::KIND_PEEK_BACK,
                    dqsr_pkg::KIND_FIND,
                    dqsr_pkg::KIND_REMOVE,
                    dqsr_pkg::KIND_LIST:
                    begin
                        if (stat.empty)
                        begin
                            cmd.status = dqsr_pkg::STAT_EMPTY;
                        end
                        else
                        begin
                            cmd.emit      = 1'b0;
                            cmd.pop_front = (stat.kind == dqsr_pkg::KIND_POP_FRONT);
                            cmd.pop_back  = (stat.kind == dqsr_pkg::KIND_POP_BACK);
                            cmd.rd_front  = (stat.kind == dqsr_pkg::KIND_POP_FRONT) ||
                                            (stat.kind == dqsr_pkg::KIND_PEEK_FRONT);
                            cmd.rd_back   = (stat.kind == dqsr_pkg::KIND_POP_BACK) ||
                                            (stat.kind == dqsr_pkg::KIND_PEEK_BACK);
                        end
                    end
                    default:
                    begin
                        cmd.status = dqsr_pkg::STAT_OK;
                    end
                endcase
            end
            dqsr_pkg::ST_END_READ:
            begin
                cmd.emit   = 1'b1;
                cmd.val_rd = 1'b1;
            end
            dqsr_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.chk_vld)
                begin
                    case (stat.kind)
                        dqsr_pkg::KIND_FIND:
                        begin
                            if (stat.chk_match)
                            begin
                                cmd.emit   = 1'b1;
                                cmd.val_rd = 1'b1;
                            end
                            else if (stat.chk_last)
                            begin
                                cmd.emit   = 1'b1;
                                cmd.status = dqsr_pkg::STAT_NOT_FOUND;
                            end
                        end
                        dqsr_pkg::KIND_REMOVE:
                        begin
                            cmd.compact = 1'b1;
                            if (stat.chk_last)
                            begin
                                cmd.commit = 1'b1;
                                cmd.emit   = 1'b1;
                                cmd.status = stat.none_removed ? dqsr_pkg::STAT_NOT_FOUND
                                                               : dqsr_pkg::STAT_OK;
                            end
                        end
                        dqsr_pkg::KIND_LIST:
                        begin
                            cmd.emit   = 1'b1;
                            cmd.val_rd = 1'b1;
                            cmd.last   = stat.chk_last;
                        end
                        default:
                        begin
                            cmd.scan = 1'b0;
                        end
                    endcase
                end
            end
            default:
            begin
                cmd.load = 1'b0;
            end
        endcase
    end

    assign busy = (state_reg != dqsr_pkg::ST_IDLE);

    `DQSR_ASSERT_NEXT(a_last_returns_idle, cmd.emit && cmd.last,
        state_reg == dqsr_pkg::ST_IDLE, "final result not followed by idle")
    `DQSR_ASSERT_IMPLY(a_load_only_idle, cmd.load, state_reg == dqsr_pkg::ST_IDLE,
        "operation loaded outside idle")

endmodule

[design/dqsr_dpath.sv]
// Datapath for the deque: ring memory, pointers, scan counters and result register.
// Depends on dqsr_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "deque_with_search_remove_unit_assert.svh"

module dqsr_dpath
#(
    parameter int CAPACITY  = 32,
    parameter int WORD_BITS = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  dqsr_pkg::op_t      op,
    input  dqsr_pkg::cmd_t     cmd,
    output dqsr_pkg::stat_t    stat,
    output dqsr_pkg::result_t  result,
    output logic               result_valid
);

    localparam int IW = $clog2(CAPACITY);
    localparam int OW = $clog2(CAPACITY + 1);

    logic [WORD_BITS-1:0] mem [CAPACITY];

    logic [IW-1:0]                 front_reg, front_next;
    logic [OW-1:0]                 occ_reg, occ_next;
    logic [OW-1:0]                 rd_off_reg, rd_off_next;
    logic [OW-1:0]                 kept_reg, kept_next;
    logic [OW-1:0]                 chk_off_reg, chk_off_next;
    logic                          chk_vld_reg, chk_vld_next;
    logic                          result_valid_reg, result_valid_next;
    logic [dqsr_pkg::KIND_W-1:0]   kind_reg;
    logic [WORD_BITS-1:0]          word_reg;
    logic [WORD_BITS-1:0]          rd_data_reg;
    dqsr_pkg::result_t             result_reg, result_next;

    logic [IW-1:0]        front_inc, front_dec;
    logic [OW-1:0]        scan_limit, kept_plus;
    logic                 full, empty, match, issue, drop, chk_last;
    logic                 rd_en, wr_en;
    logic [IW-1:0]        rd_addr, wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] base,
                                              input logic [OW-1:0] off);
        logic [IW:0] sum;
        sum = {1'b0, base} + (IW+1)'(off);
        if (sum >= (IW+1)'(CAPACITY))
        begin
            sum = sum - (IW+1)'(CAPACITY);
        end
        return sum[IW-1:0];
    endfunction

    always_comb
    begin
        front_inc = (front_reg == IW'(CAPACITY - 1)) ? '0 : front_reg + 1'b1;
        front_dec = (front_reg == '0) ? IW'(CAPACITY - 1) : front_reg - 1'b1;
        full      = (occ_reg == OW'(CAPACITY));
        empty     = (occ_reg == '0);
        if ((kind_reg == dqsr_pkg::KIND_LIST) && (int'(occ_reg) > dqsr_pkg::MAX_RESULTS))
        begin
            scan_limit = OW'(dqsr_pkg::MAX_RESULTS);
        end
        else
        begin
            scan_limit = occ_reg;
        end
        match     = (rd_data_reg == word_reg);
        kept_plus = kept_reg + OW'(!match);
        issue     = cmd.scan && (rd_off_reg < scan_limit);
        drop      = cmd.compact && chk_vld_reg && !match;
        chk_last  = chk_vld_reg && (chk_off_reg == scan_limit - 1'b1);
    end

    always_comb
    begin
        rd_en = cmd.rd_front || cmd.rd_back || issue;
        if (cmd.rd_front)
        begin
            rd_addr = front_reg;
        end
        else if (cmd.rd_back)
        begin
            rd_addr = slot_of(front_reg, occ_reg - 1'b1);
        end
        else
        begin
            rd_addr = slot_of(front_reg, rd_off_reg);
        end

        wr_en = cmd.push_front || cmd.push_back || drop;
        if (cmd.push_front)
        begin
            wr_addr = front_dec;
        end
        else if (cmd.push_back)
        begin
            wr_addr = slot_of(front_reg, occ_reg);
        end
        else
        begin
            wr_addr = slot_of(front_reg, kept_reg);
        end
        wr_data = (cmd.push_front || cmd.push_back) ? word_reg : rd_data_reg;
    end

    always_comb
    begin
        front_next        = front_reg;
        occ_next          = occ_reg;
        rd_off_next       = rd_off_reg;
        kept_next         = kept_reg;
        chk_off_next      = chk_off_reg;
        chk_vld_next      = issue;
        result_valid_next = cmd.emit;

        if (cmd.load)
        begin
            rd_off_next  = '0;
            kept_next    = '0;
            chk_vld_next = 1'b0;
        end
        if (issue)
        begin
            rd_off_next  = rd_off_reg + 1'b1;
            chk_off_next = rd_off_reg;
        end
        if (drop)
        begin
            kept_next = kept_reg + 1'b1;
        end
        if (cmd.push_front)
        begin
            front_next = front_dec;
        end
        if (cmd.pop_front)
        begin
            front_next = front_inc;
        end
        if (cmd.push_front || cmd.push_back)
        begin
            occ_next = occ_reg + 1'b1;
        end
        else if (cmd.pop_front || cmd.pop_back)
        begin
            occ_next = occ_reg - 1'b1;
        end
        else if (cmd.commit)
        begin
            occ_next = kept_plus;
        end

        result_next.value_res = cmd.val_rd ? dqsr_pkg::VALUE_W'(rd_data_reg) : '0;
        result_next.status    = cmd.status;
        result_next.count     = dqsr_pkg::COUNT_W'(occ_next);
        result_next.last      = cmd.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg        <= '0;
            occ_reg          <= '0;
            rd_off_reg       <= '0;
            kept_reg         <= '0;
            chk_off_reg      <= '0;
            chk_vld_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            front_reg        <= front_next;
            occ_reg          <= occ_next;
            rd_off_reg       <= rd_off_next;
            kept_reg         <= kept_next;
            chk_off_reg      <= chk_off_next;
            chk_vld_reg      <= chk_vld_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= op.kind;
            word_reg <= WORD_BITS'(op.value);
        end
        if (cmd.emit)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign stat.kind         = kind_reg;
    assign stat.empty        = empty;
    assign stat.full         = full;
    assign stat.chk_vld      = chk_vld_reg;
    assign stat.chk_last     = chk_last;
    assign stat.chk_match    = match;
    assign stat.none_removed = (kept_plus == occ_reg);

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    `DQSR_ASSERT_IMPLY(a_occ_bound, 1'b1, occ_reg <= OW'(CAPACITY),
        "occupancy exceeds capacity")
    `DQSR_ASSERT_IMPLY(a_front_bound, 1'b1, front_reg <= IW'(CAPACITY - 1),
        "front index outside the ring")
    `DQSR_ASSERT_IMPLY(a_push_not_full, cmd.push_front || cmd.push_back, !full,
        "push performed into a full ring")
    `DQSR_ASSERT_IMPLY(a_commit_at_end, cmd.commit, chk_last,
        "remove committed before the scan finished")

endmodule

[design/deque_with_search_remove_unit.sv]
// Push and unknown kinds give their result from the decode state; pop and peek on a
// non-empty ring read the memory and give it from the end-read state; find, remove
// and list walk the ring one entry per cycle through the single memory read port.
// A new item is taken the cycle after the final result is registered; results
// cannot be stalled. Reset empties the ring; stored words stay undefined until written.
`timescale 1ns / 1ps

module deque_with_search_remove_unit
#(
    parameter int CAPACITY  = 32,
    parameter int WORD_BITS = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  dqsr_pkg::op_t      op,
    output logic               busy,
    output dqsr_pkg::result_t  result,
    output logic               result_valid
);

    dqsr_pkg::cmd_t  cmd;
    dqsr_pkg::stat_t stat;

    dqsr_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    dqsr_dpath
    #(
        .CAPACITY  (CAPACITY),
        .WORD_BITS (WORD_BITS)
    )
    u_dpath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .cmd          (cmd),
        .stat         (stat),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule
